// ===== src/glyph_text_blitter_defines.svh =====
// assertion macros for the glyph text blitter checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef GLYPH_TEXT_BLITTER_DEFINES_SVH
`define GLYPH_TEXT_BLITTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gtb_pkg.sv =====
// shared types, constants and helpers of the glyph text blitter
// no dependencies
package gtb_pkg;

  localparam int GTB_GLYPH_COUNT    = 256;
  localparam int GTB_MAX_GLYPH_SIZE = 64;
  localparam logic [12:0] DST_LIMIT = 13'd4096;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_DRAW  = 2'd2
  } gtb_action_e;

  typedef enum logic [1:0] {
    REG_DST_WIDTH   = 2'd0,
    REG_DST_HEIGHT  = 2'd1,
    REG_FONT_HEIGHT = 2'd2
  } gtb_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROWS
  } gtb_state_e;

  // glyph store write request
  typedef struct packed {
    logic        en;
    logic [7:0]  code;
    logic [5:0]  row;
    logic [6:0]  width;
    logic [63:0] bits;
  } gtb_wr_t;

  // glyph store read request
  typedef struct packed {
    logic       width_en;
    logic       row_en;
    logic [7:0] code;
    logic [5:0] row;
  } gtb_rd_t;

  // ones in bits below n, n saturates at 64
  function automatic logic [63:0] low_ones(input logic [6:0] n);
    logic [63:0] m;
    if (n >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << n) - 64'd1;
    end
    return m;
  endfunction

endpackage

// ===== src/gtb_ifs.sv =====
// valid/ready channel interfaces of the glyph text blitter
// depends on gtb_pkg
interface gtb_in_if import gtb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic        [7:0]  char_code;
  logic        [5:0]  glyph_row;
  logic        [6:0]  glyph_width;
  logic        [63:0] row_bits;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;

  modport source (output valid, action, char_code, glyph_row, glyph_width, row_bits,
                  start_x, start_y, input ready);
  modport sink   (input valid, action, char_code, glyph_row, glyph_width, row_bits,
                  start_x, start_y, output ready);
endinterface

interface gtb_out_if import gtb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic        [11:0] dest_row;
  logic signed [15:0] column_origin;
  logic        [63:0] pixel_mask;
  logic               last;

  modport source (output valid, dest_row, column_origin, pixel_mask, last, input ready);
  modport sink   (input valid, dest_row, column_origin, pixel_mask, last, output ready);
endinterface

interface gtb_cfg_if import gtb_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/gtb_glyph_store.sv =====
// glyph store: row memory and width memory with per-glyph valid bits
// depends on gtb_pkg; read data registered
module gtb_glyph_store import gtb_pkg::*; #(
  parameter int GLYPH_COUNT    = GTB_GLYPH_COUNT,
  parameter int MAX_GLYPH_SIZE = GTB_MAX_GLYPH_SIZE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gtb_wr_t     wr_i,
  input  gtb_rd_t     rd_i,
  output logic [6:0]  width_o,
  output logic [63:0] row_o
);

  localparam int CW    = $clog2(GLYPH_COUNT);
  localparam int RW    = $clog2(MAX_GLYPH_SIZE);
  localparam int DEPTH = GLYPH_COUNT * MAX_GLYPH_SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic [63:0]      rows_mem   [DEPTH];
  logic [6:0]       widths_mem [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0] present_q;

  logic [AW-1:0] waddr, raddr;
  logic [63:0]   row_q;
  logic [6:0]    width_q;
  logic          width_vld_q;

  // flat row address: code * rows per glyph + row
  assign waddr = AW'(wr_i.code[CW-1:0]) * AW'(MAX_GLYPH_SIZE) + AW'(wr_i.row[RW-1:0]);
  assign raddr = AW'(rd_i.code[CW-1:0]) * AW'(MAX_GLYPH_SIZE) + AW'(rd_i.row[RW-1:0]);

  // row memory, read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      rows_mem[waddr] <= wr_i.bits;
    end
    if (rd_i.row_en) begin
      row_q <= rows_mem[raddr];
    end
  end

  // width memory
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      widths_mem[wr_i.code[CW-1:0]] <= wr_i.width;
    end
    if (rd_i.width_en) begin
      width_q     <= widths_mem[rd_i.code[CW-1:0]];
      width_vld_q <= present_q[rd_i.code[CW-1:0]];
    end
  end

  // written-once flags, so an unloaded glyph reads as absent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (wr_i.en) begin
      present_q[wr_i.code[CW-1:0]] <= 1'b1;
    end
  end

  assign width_o = width_vld_q ? width_q : 7'd0;
  assign row_o   = row_q;

endmodule

// ===== src/glyph_text_blitter.sv =====
// glyph text blitter top level: item decode, draw sequencer and output register
// depends on gtb_pkg, gtb_ifs and gtb_glyph_store
//
// A load or start item is taken in idle and the block is ready again in the next
// one. A draw item passes a width memory read, then clipping setup, then a fetch
// per visible glyph row: the row memory has one read port and one row is fetched
// per cycle while the waiting row can move on, so the input is held until the
// last row is fetched. A fetched row waits in the read register, then moves to
// an output register, and beats drain from it while the next item is taken. No
// clearing pass runs after reset; glyph widths carry a valid flag per glyph.
module glyph_text_blitter import gtb_pkg::*; #(
  parameter int GLYPH_COUNT    = GTB_GLYPH_COUNT,
  parameter int MAX_GLYPH_SIZE = GTB_MAX_GLYPH_SIZE
) (
  input  logic clk_i,
  input  logic rst_ni,
  gtb_cfg_if.sink   cfg_i,
  gtb_in_if.sink    in_i,
  gtb_out_if.source out_o
);

  localparam int RW  = $clog2(MAX_GLYPH_SIZE);
  localparam int RCW = $clog2(MAX_GLYPH_SIZE + 1);

  gtb_state_e state_q, state_d;

  logic [12:0] dst_w_q, dst_h_q;
  logic [6:0]  font_h_q;
  logic signed [15:0] pen_q, top_q;

  logic [7:0]     code_q;
  logic           code_ok_q;
  logic signed [15:0] org_q;
  logic [63:0]    wmask_q;
  logic [RCW-1:0] r_q, r_last_q;
  logic [11:0]    dy_q;

  logic               pend_q, pend_last_q;
  logic [11:0]        pend_row_q;
  logic signed [15:0] pend_org_q;
  logic [63:0]        pend_mask_q;

  logic               ov_q, out_last_q;
  logic [11:0]        out_row_q;
  logic signed [15:0] out_org_q;
  logic [63:0]        out_mask_q;

  gtb_wr_t     wr;
  gtb_rd_t     rd;
  logic [6:0]  glyph_w;
  logic [63:0] row_data;

  logic in_ready, in_acc, move, issue, is_last;
  logic setup_go, setup_rows;

  // ---------------------------------------------------------------
  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_w_q  <= 13'd640;
      dst_h_q  <= 13'd480;
      font_h_q <= 7'd12;
    end else if (cfg_i.valid) begin
      case (gtb_reg_e'(cfg_i.index))
        REG_DST_WIDTH:   dst_w_q  <= cfg_i.data;
        REG_DST_HEIGHT:  dst_h_q  <= cfg_i.data;
        REG_FONT_HEIGHT: font_h_q <= cfg_i.data[6:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // setup math: clip window in columns and rows
  logic [12:0]        dw_sat, dh_sat;
  logic [RCW-1:0]     rows, r_lo, r_hi;
  logic signed [17:0] pen_x, top_x, neg_pen, neg_top, col_room, row_room, pen_sum;
  logic [6:0]         m_lo, m_hi;
  logic               draw_ok;

  always_comb begin
    dw_sat = (dst_w_q > DST_LIMIT) ? DST_LIMIT : dst_w_q;
    dh_sat = (dst_h_q > DST_LIMIT) ? DST_LIMIT : dst_h_q;
    rows   = (font_h_q > 7'(MAX_GLYPH_SIZE)) ? RCW'(MAX_GLYPH_SIZE) : RCW'(font_h_q);

    pen_x    = 18'(pen_q);
    top_x    = 18'(top_q);
    neg_pen  = -pen_x;
    neg_top  = -top_x;
    col_room = $signed({5'd0, dw_sat}) - pen_x;
    row_room = $signed({5'd0, dh_sat}) - top_x;
    pen_sum  = pen_x + $signed({11'd0, glyph_w});

    // columns kept: max(0,-pen) up to min(width, dw-pen)
    if (!neg_pen[17] && neg_pen != 18'sd0) begin
      m_lo = (neg_pen >= 18'sd64) ? 7'd64 : neg_pen[6:0];
    end else begin
      m_lo = 7'd0;
    end
    if (col_room[17] || col_room == 18'sd0) begin
      m_hi = 7'd0;
    end else if (col_room >= $signed({11'd0, glyph_w})) begin
      m_hi = glyph_w;
    end else begin
      m_hi = col_room[6:0];
    end

    // glyph rows kept: max(0,-top) up to min(rows, dh-top)
    if (!neg_top[17] && neg_top != 18'sd0) begin
      r_lo = (neg_top >= $signed(18'(rows))) ? rows : RCW'(neg_top);
    end else begin
      r_lo = '0;
    end
    if (row_room[17] || row_room == 18'sd0) begin
      r_hi = '0;
    end else if (row_room >= $signed(18'(rows))) begin
      r_hi = rows;
    end else begin
      r_hi = RCW'(row_room);
    end

    draw_ok = code_ok_q && (dw_sat != 13'd0) && (dh_sat != 13'd0) && (glyph_w != 7'd0);
  end

  // ---------------------------------------------------------------
  // sequencer
  assign in_acc  = in_i.valid && in_ready;
  assign move    = pend_q && (!ov_q || out_o.ready);
  assign is_last = (r_q == r_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready   = 1'b0;
    issue      = 1'b0;
    setup_go   = 1'b0;
    setup_rows = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc && gtb_action_e'(in_i.action) == ACT_DRAW) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = ST_IDLE;
        if (draw_ok) begin
          setup_go = 1'b1;
          if (r_lo < r_hi) begin
            setup_rows = 1'b1;
            state_d    = ST_ROWS;
          end
        end
      end
      ST_ROWS: begin
        if (!pend_q || move) begin
          issue = 1'b1;
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready = in_ready;

  // ---------------------------------------------------------------
  // glyph store requests
  always_comb begin
    wr       = '0;
    wr.code  = in_i.char_code;
    wr.row   = in_i.glyph_row;
    wr.width = (in_i.glyph_width > 7'(MAX_GLYPH_SIZE)) ? 7'd0 : in_i.glyph_width;
    wr.bits  = in_i.row_bits;
    wr.en    = in_acc && gtb_action_e'(in_i.action) == ACT_LOAD
               && ({1'b0, in_i.char_code} < 9'(GLYPH_COUNT))
               && ({1'b0, in_i.glyph_row} < 7'(MAX_GLYPH_SIZE));

    rd          = '0;
    rd.width_en = in_acc && gtb_action_e'(in_i.action) == ACT_DRAW;
    rd.row_en   = issue;
    rd.code     = (state_q == ST_IDLE) ? in_i.char_code : code_q;
    rd.row      = 6'(r_q[RW-1:0]);
  end

  gtb_glyph_store #(
    .GLYPH_COUNT    (GLYPH_COUNT),
    .MAX_GLYPH_SIZE (MAX_GLYPH_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .rd_i    (rd),
    .width_o (glyph_w),
    .row_o   (row_data)
  );

  // ---------------------------------------------------------------
  // pen and top row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q <= '0;
      top_q <= '0;
    end else if (in_acc && gtb_action_e'(in_i.action) == ACT_START) begin
      pen_q <= in_i.start_x;
      top_q <= in_i.start_y;
    end else if (setup_go) begin
      pen_q <= (pen_sum > 18'sd32767) ? 16'sh7fff : pen_sum[15:0];
    end
  end

  // draw context
  always_ff @(posedge clk_i) begin
    if (rd.width_en) begin
      code_q    <= in_i.char_code;
      code_ok_q <= {1'b0, in_i.char_code} < 9'(GLYPH_COUNT);
    end
    if (setup_rows) begin
      org_q    <= pen_q;
      wmask_q  <= low_ones(m_hi) & ~low_ones(m_lo);
      r_q      <= r_lo;
      r_last_q <= r_hi - RCW'(1);
      dy_q     <= top_q[11:0] + 12'(r_lo);
    end else if (issue) begin
      r_q  <= r_q + RCW'(1);
      dy_q <= dy_q + 12'd1;
    end
  end

  // ---------------------------------------------------------------
  // fetched row waiting in the read register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (issue) begin
      pend_q <= 1'b1;
    end else if (move) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_last_q <= is_last;
      pend_row_q  <= dy_q;
      pend_org_q  <= org_q;
      pend_mask_q <= wmask_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (move) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_row_q  <= pend_row_q;
      out_org_q  <= pend_org_q;
      out_mask_q <= row_data & pend_mask_q;
      out_last_q <= pend_last_q;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.dest_row      = out_row_q;
  assign out_o.column_origin = out_org_q;
  assign out_o.pixel_mask    = out_mask_q;
  assign out_o.last          = out_last_q;

endmodule

// ===== src/gtb_checker.sv =====
// port-level checks of the glyph text blitter, bound to the top level
// depends on gtb_pkg and glyph_text_blitter_defines.svh
`include "glyph_text_blitter_defines.svh"

module gtb_checker import gtb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_dest_row,
  input logic [15:0] out_column_origin,
  input logic [63:0] out_pixel_mask,
  input logic        out_last
);

  logic in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // a stalled result beat holds
  `GTB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_dest_row) && $stable(out_column_origin) && $stable(out_pixel_mask) && $stable(out_last), "stalled result beat changed")

  // rows of one glyph follow without a gap
  `GTB_ASSERT_NXT(a_rows_no_gap, out_beat && !out_last, out_valid, "gap inside a draw's beats")

  // a draw always passes through setup, so the input is not ready right after it
  `GTB_ASSERT_NXT(a_draw_busy, in_beat && in_action == ACT_DRAW, !in_ready, "ready right after a draw beat")

  // load and start items leave the input ready again
  `GTB_ASSERT_NXT(a_short_items, in_beat && (in_action == ACT_LOAD || in_action == ACT_START), in_ready, "load or start held the input")

endmodule

bind glyph_text_blitter gtb_checker u_gtb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid          (in_i.valid),
  .in_ready          (in_i.ready),
  .in_action         (in_i.action),
  .out_valid         (out_o.valid),
  .out_ready         (out_o.ready),
  .out_dest_row      (out_o.dest_row),
  .out_column_origin (out_o.column_origin),
  .out_pixel_mask    (out_o.pixel_mask),
  .out_last          (out_o.last)
);

// ===== verif/gtb_blit_checker.sv =====
`timescale 1ns / 100ps
// scoreboard of the glyph text blitter: mirrors font, pen and registers from the
// observed beats and checks every mask beat; depends on gtb_pkg and gtb_ifs
module gtb_blit_checker import gtb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  gtb_cfg_if   cfg_mon,
  gtb_in_if    item_mon,
  gtb_out_if   mask_mon,
  output int   err_cnt_o,
  output int   pending_o
);

  localparam int DIM_LIMIT = 4096;
  localparam int PEN_MAX   = 32767;

  typedef struct packed {
    logic        [11:0] row;
    logic signed [15:0] col;
    logic        [63:0] mask;
    logic               last;
  } mask_beat_t;

  // mirrored block state
  logic [63:0] font_bits [GTB_GLYPH_COUNT][GTB_MAX_GLYPH_SIZE];
  logic [6:0]  font_wid [GTB_GLYPH_COUNT];
  int          pen_col;
  int          top_row;
  logic [12:0] dst_w;
  logic [12:0] dst_h;
  logic [6:0]  font_h;
  mask_beat_t  exp_masks [$];
  int          errs;

  // queue the clipped row masks of one drawn glyph, then move the pen
  task automatic predict_draw(input logic [7:0] code);
    int          dw;
    int          dh;
    int          w;
    int          rows;
    int          dy;
    int          col;
    logic [63:0] clip;
    logic        have;
    mask_beat_t  held;
    dw = (dst_w > DIM_LIMIT) ? DIM_LIMIT : int'(dst_w);
    dh = (dst_h > DIM_LIMIT) ? DIM_LIMIT : int'(dst_h);
    w  = int'(font_wid[code]);
    if (dw == 0 || dh == 0 || w == 0) return;
    // columns left of zero or past the destination width are cleared
    clip = '0;
    for (int k = 0; k < w; k++) begin
      col = pen_col + k;
      if (col >= 0 && col < dw) clip[k] = 1'b1;
    end
    rows = (font_h > GTB_MAX_GLYPH_SIZE) ? GTB_MAX_GLYPH_SIZE : int'(font_h);
    have = 1'b0;
    held = '0;
    for (int r = 0; r < rows; r++) begin
      dy = top_row + r;
      if (dy >= 0 && dy < dh) begin
        if (have) exp_masks.push_back(held);
        held.row  = dy[11:0];
        held.col  = pen_col[15:0];
        held.mask = font_bits[code][r] & clip;
        held.last = 1'b0;
        have = 1'b1;
      end
    end
    // final visible row carries last
    if (have) begin
      held.last = 1'b1;
      exp_masks.push_back(held);
    end
    pen_col = (pen_col + w > PEN_MAX) ? PEN_MAX : pen_col + w;
  endtask

  // compare one mask beat with the oldest expectation
  task automatic check_beat();
    mask_beat_t want;
    logic       bad;
    if (exp_masks.size() == 0) begin
      $display("%0t: mask beat with none expected: row %0d col %0d mask %h last %0b",
               $time, mask_mon.dest_row, mask_mon.column_origin, mask_mon.pixel_mask,
               mask_mon.last);
      errs++;
      return;
    end
    want = exp_masks.pop_front();
    bad  = 1'b0;
    if (mask_mon.dest_row !== want.row) begin
      $display("%0t: dest_row expected %0d got %0d", $time, want.row, mask_mon.dest_row);
      bad = 1'b1;
    end
    if (mask_mon.column_origin !== want.col) begin
      $display("%0t: column_origin expected %0d got %0d", $time, want.col,
               mask_mon.column_origin);
      bad = 1'b1;
    end
    if (mask_mon.pixel_mask !== want.mask) begin
      $display("%0t: pixel_mask expected %h got %h", $time, want.mask, mask_mon.pixel_mask);
      bad = 1'b1;
    end
    if (mask_mon.last !== want.last) begin
      $display("%0t: last expected %0b got %0b", $time, want.last, mask_mon.last);
      bad = 1'b1;
    end
    if (bad) errs++;
  endtask

  // register writes, item beats and mask beats, sampled at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (font_wid[i]) font_wid[i] = '0;
      pen_col = 0;
      top_row = 0;
      dst_w   = 13'd640;
      dst_h   = 13'd480;
      font_h  = 7'd12;
      exp_masks.delete();
      errs = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_DST_WIDTH:   dst_w = cfg_mon.data;
          REG_DST_HEIGHT:  dst_h = cfg_mon.data;
          REG_FONT_HEIGHT: font_h = cfg_mon.data[6:0];
          default: ;
        endcase
      end
      if (item_mon.valid && item_mon.ready) begin
        case (item_mon.action)
          ACT_LOAD: begin
            // too wide a glyph is stored as absent
            font_wid[item_mon.char_code] =
              (item_mon.glyph_width > GTB_MAX_GLYPH_SIZE) ? '0 : item_mon.glyph_width;
            font_bits[item_mon.char_code][item_mon.glyph_row] = item_mon.row_bits;
          end
          ACT_START: begin
            pen_col = item_mon.start_x;
            top_row = item_mon.start_y;
          end
          ACT_DRAW: predict_draw(item_mon.char_code);
          default: ;
        endcase
      end
      if (mask_mon.valid && mask_mon.ready) check_beat();
    end
    err_cnt_o <= errs;
    pending_o <= exp_masks.size();
  end

endmodule

// ===== verif/tb_glyph_text_blitter.sv =====
`timescale 1ns / 100ps
// testbench top of the glyph text blitter: clock, reset, beat drivers and verdict
// depends on gtb_pkg, gtb_ifs, glyph_text_blitter and gtb_blit_checker
module tb_glyph_text_blitter;
  import gtb_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam int         ITEM_TARGET  = 410;
  localparam int         CYCLE_LIMIT  = 1_200_000;
  localparam int         DRAIN_CYCLES = 20;

  logic clk_i;
  logic rst_ni;
  int   err_cnt;
  int   pending;

  gtb_cfg_if cfg_if ();
  gtb_in_if  item_if ();
  gtb_out_if mask_if ();

  glyph_text_blitter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (item_if),
    .out_o  (mask_if)
  );

  gtb_blit_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_mon   (cfg_if),
    .item_mon  (item_if),
    .mask_mon  (mask_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  // stimulus view of the font, keeps draws away from rows never loaded
  logic [6:0]  shadow_wid [GTB_GLYPH_COUNT];
  logic [63:0] shadow_loaded [GTB_GLYPH_COUNT];
  int          font_rows;
  int          dim_w;
  int          dim_h;
  int          item_cnt;
  bit          calm;
  int          ready_stall;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // present one item beat and hold it until taken
  task automatic send_item(input logic [1:0] act, input logic [7:0] code,
                           input logic [5:0] grow, input logic [6:0] gwid,
                           input logic [63:0] bits, input logic [15:0] sx,
                           input logic [15:0] sy);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.action      <= act;
    item_if.char_code   <= code;
    item_if.glyph_row   <= grow;
    item_if.glyph_width <= gwid;
    item_if.row_bits    <= bits;
    item_if.start_x     <= sx;
    item_if.start_y     <= sy;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (act == ACT_LOAD) begin
      shadow_wid[code] = (gwid > GTB_MAX_GLYPH_SIZE) ? '0 : gwid;
      shadow_loaded[code][grow] = 1'b1;
    end
    if (act != ACT_UNUSED) item_cnt++;
  endtask

  task automatic load_row(input logic [7:0] code, input logic [5:0] grow,
                          input logic [6:0] gwid, input logic [63:0] bits);
    send_item(ACT_LOAD, code, grow, gwid, bits, 16'($urandom), 16'($urandom));
  endtask

  task automatic set_pen(input logic signed [15:0] x, input logic signed [15:0] y);
    send_item(ACT_START, 8'($urandom), 6'($urandom), 7'($urandom), {$urandom, $urandom},
              x, y);
  endtask

  // a present glyph may be drawn only once all its rows in use are loaded
  function automatic bit drawable(input logic [7:0] code);
    logic [63:0] need;
    need = (font_rows >= 64) ? '1 : (64'd1 << font_rows) - 64'd1;
    return shadow_wid[code] == '0 || (shadow_loaded[code] & need) == need;
  endfunction

  task automatic draw_glyph(input logic [7:0] code);
    if (drawable(code)) begin
      send_item(ACT_DRAW, code, 6'($urandom), 7'($urandom), {$urandom, $urandom},
                16'($urandom), 16'($urandom));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_DST_WIDTH:   dim_w = (val > 13'd4096) ? 4096 : int'(val);
      REG_DST_HEIGHT:  dim_h = (val > 13'd4096) ? 4096 : int'(val);
      REG_FONT_HEIGHT: font_rows = (val[6:0] > 7'd64) ? 64 : int'(val[6:0]);
      default: ;
    endcase
  endtask

  // drop valid and wait until every mask beat is out and the block is quiet
  task automatic settle();
    item_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // mask sink with random back-pressure
  initial begin
    mask_if.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      ready_stall = calm ? 0 : $urandom_range(0, 8);
      repeat (ready_stall) begin
        mask_if.ready <= 1'b0;
        @(negedge clk_i);
      end
      mask_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!mask_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // reset, directed items, then randomized phases
  initial begin : stim
    int         cw;
    int         ch;
    int         cf;
    int         phase_no;
    int         n_glyphs;
    int         steps;
    int         pick;
    logic [6:0] wid;
    logic [7:0] code;
    logic [7:0] pool [$];

    rst_ni              = 1'b0;
    item_if.valid       = 1'b0;
    item_if.action      = ACT_LOAD;
    item_if.char_code   = '0;
    item_if.glyph_row   = '0;
    item_if.glyph_width = '0;
    item_if.row_bits    = '0;
    item_if.start_x     = '0;
    item_if.start_y     = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_DST_WIDTH;
    cfg_if.data         = '0;
    foreach (shadow_wid[i]) begin
      shadow_wid[i]    = '0;
      shadow_loaded[i] = '0;
    end
    dim_w     = 640;
    dim_h     = 480;
    font_rows = 12;
    item_cnt  = 0;
    calm      = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: three-row font, widest and narrowest glyphs, absent glyphs
    write_reg(REG_FONT_HEIGHT, 13'd3);
    write_reg(REG_UNUSED, '1);
    load_row(8'd0, 6'd0, 7'd64, '1);
    load_row(8'd0, 6'd1, 7'd64, '0);
    load_row(8'd0, 6'd2, 7'd64, 64'hA5A5_5A5A_F00F_0FF0);
    load_row(8'd255, 6'd0, 7'd1, '1);
    load_row(8'd255, 6'd1, 7'd1, '1);
    load_row(8'd255, 6'd2, 7'd1, 64'd1);
    // too wide, so stored as absent
    load_row(8'd7, 6'd63, 7'd127, '1);
    // zero width marks absent
    load_row(8'd9, 6'd0, 7'd0, 64'h1234_5678_9ABC_DEF0);
    send_item(ACT_UNUSED, 8'd0, 6'd0, 7'd0, '1, '1, '1);
    // clipped on the left and above
    set_pen(-16'sd10, -16'sd1);
    draw_glyph(8'd0);
    draw_glyph(8'd255);
    draw_glyph(8'd7);
    draw_glyph(8'd9);
    // beyond the right edge: empty masks, bottom row cut, pen saturates
    set_pen(16'sd32697, 16'sd478);
    draw_glyph(8'd0);
    draw_glyph(8'd0);
    draw_glyph(8'd255);
    set_pen(-16'sd32768, 16'sd0);
    draw_glyph(8'd255);
    // right edge cuts into the glyph
    set_pen(16'sd636, 16'sd0);
    draw_glyph(8'd0);

    // random phases, the first ones at fixed corners of the register space
    phase_no = 0;
    while (item_cnt < ITEM_TARGET) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      case (phase_no)
        0: begin cw = 4096; ch = 4096; cf = 64;  end
        1: begin cw = 0;    ch = 480;  cf = 8;   end
        2: begin cw = 640;  ch = 0;    cf = 8;   end
        3: begin cw = 8191; ch = 8191; cf = 127; end
        4: begin cw = 1;    ch = 1;    cf = 5;   end
        5: begin cw = 640;  ch = 480;  cf = 0;   end
        6: begin cw = 13;   ch = 9;    cf = 4;   end
        default: begin
          cw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 200);
          ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 200);
          cf = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 10);
        end
      endcase
      write_reg(REG_DST_WIDTH, 13'(cw));
      write_reg(REG_DST_HEIGHT, 13'(ch));
      write_reg(REG_FONT_HEIGHT, 13'(cf));

      // load a few complete glyphs for this font height
      n_glyphs = (font_rows > 16) ? 1 : $urandom_range(1, 3);
      repeat (n_glyphs) begin
        code = 8'($urandom_range(0, 255));
        wid  = 7'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(1, 64));
        for (int r = 0; r < ((font_rows == 0) ? 1 : font_rows); r++) begin
          load_row(code, 6'(r), wid, {$urandom, $urandom});
        end
        pool.push_back(code);
      end

      // text runs with noise mixed in
      set_pen(16'($urandom_range(0, dim_w + 140) - 70),
              16'($urandom_range(0, dim_h + 2 * font_rows + 4) - (font_rows + 2)));
      steps = $urandom_range(15, 40);
      repeat (steps) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          draw_glyph(pool[$urandom_range(0, pool.size() - 1)]);
        end else if (pick < 65) begin
          set_pen(16'($urandom_range(0, dim_w + 140) - 70),
                  16'($urandom_range(0, dim_h + 2 * font_rows + 4) - (font_rows + 2)));
        end else if (pick < 70) begin
          set_pen(16'($urandom), 16'($urandom));
        end else if (pick < 80) begin
          draw_glyph(8'($urandom_range(0, 255)));
        end else if (pick < 92) begin
          load_row(8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                   7'($urandom_range(0, 127)), {$urandom, $urandom});
        end else if (pick < 96) begin
          send_item(ACT_UNUSED, 8'($urandom), 6'($urandom), 7'($urandom),
                    {$urandom, $urandom}, 16'($urandom), 16'($urandom));
        end else begin
          load_row(pool[$urandom_range(0, pool.size() - 1)], 6'($urandom_range(0, 63)),
                   7'($urandom_range(1, 64)), {$urandom, $urandom});
        end
      end
      phase_no++;
    end

    settle();
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/gtb_pkg.sv
src/gtb_ifs.sv
src/gtb_glyph_store.sv
src/glyph_text_blitter.sv
src/gtb_checker.sv
verif/gtb_blit_checker.sv
verif/tb_glyph_text_blitter.sv
